// File: src/bfe_pkg.sv
// Shared types and constants for the byte-stuffed frame encoder.
package bfe_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] STUFF_MASK = 8'h20;

    localparam logic [CFG_IDX_W-1:0] REG_FLAG     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ1 = 3'd4;

    localparam logic [BYTE_W-1:0] RESET_FLAG      = 8'd126;
    localparam logic [BYTE_W-1:0] RESET_ESCAPE    = 8'd125;
    localparam logic [BYTE_W-1:0] RESET_ADDRESS   = 8'd3;
    localparam logic [BYTE_W-1:0] RESET_CTRL_SEQ0 = 8'd0;
    localparam logic [BYTE_W-1:0] RESET_CTRL_SEQ1 = 8'd64;

    typedef struct packed {
        logic [BYTE_W-1:0] flag;
        logic [BYTE_W-1:0] escape;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] ctrl_seq0;
        logic [BYTE_W-1:0] ctrl_seq1;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] check;
        logic              first;
        logic              last;
        logic              seq;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_START,
        ST_HDR_FLAG,
        ST_HDR_ADDR,
        ST_HDR_CTRL,
        ST_HDR_XOR,
        ST_DATA,
        ST_DATA_STUFF,
        ST_CHECK,
        ST_CHECK_STUFF,
        ST_CLOSE
    } step_t;

endpackage

// File: src/bfe_front.sv
// Front end: accepts payload requests, tracks frame state and the running check byte.
module bfe_front
    import bfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] payload_byte,
    input  logic              last_byte,
    input  logic              sequence_bit,
    input  logic              queue_full,
    output logic              push,
    output cmd_t              push_cmd
);

    logic              frame_open_reg;
    logic              frame_open_next;
    logic [BYTE_W-1:0] check_reg;
    logic [BYTE_W-1:0] check_next;
    logic [BYTE_W-1:0] check_new;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    assign check_new = (frame_open_reg ? check_reg : '0) ^ payload_byte;

    always_comb
    begin
        push_cmd.data  = payload_byte;
        push_cmd.check = check_new;
        push_cmd.first = !frame_open_reg;
        push_cmd.last  = last_byte;
        push_cmd.seq   = sequence_bit;
    end

    always_comb
    begin
        frame_open_next = frame_open_reg;
        check_next      = check_reg;
        if (push)
        begin
            if (last_byte)
            begin
                frame_open_next = 1'b0;
                check_next      = '0;
            end
            else
            begin
                frame_open_next = 1'b1;
                check_next      = check_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            check_reg      <= '0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            check_reg      <= check_next;
        end
    end

endmodule

// File: src/bfe_queue.sv
// Small command queue between the front end and the line sequencer.
module bfe_queue
    import bfe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/bfe_back.sv
// Line sequencer: expands each queued command into header, stuffed and trailer bytes.
module bfe_back
    import bfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  cmd_t              head_cmd,
    input  logic              queue_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] line_byte,
    output logic              run_end,
    output logic              frame_end
);

    step_t             step_reg;
    step_t             step_next;
    step_t             cur_step;
    logic              advance;
    logic              data_hit;
    logic              check_hit;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_run_end;
    logic              emit_frame_end;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] line_byte_reg;
    logic              run_end_reg;
    logic              frame_end_reg;

    assign advance   = !queue_empty && (!out_valid_reg || !out_stall);
    assign data_hit  = (head_cmd.data == cfg.flag) || (head_cmd.data == cfg.escape);
    assign check_hit = (head_cmd.check == cfg.flag) || (head_cmd.check == cfg.escape);
    assign ctrl      = head_cmd.seq ? cfg.ctrl_seq1 : cfg.ctrl_seq0;

    always_comb
    begin
        if (step_reg == ST_START)
        begin
            cur_step = head_cmd.first ? ST_HDR_FLAG : ST_DATA;
        end
        else
        begin
            cur_step = step_reg;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        pop       = 1'b0;
        if (advance)
        begin
            case (cur_step)
                ST_HDR_FLAG:  step_next = ST_HDR_ADDR;
                ST_HDR_ADDR:  step_next = ST_HDR_CTRL;
                ST_HDR_CTRL:  step_next = ST_HDR_XOR;
                ST_HDR_XOR:   step_next = ST_DATA;
                ST_DATA:
                begin
                    if (data_hit)
                    begin
                        step_next = ST_DATA_STUFF;
                    end
                    else if (head_cmd.last)
                    begin
                        step_next = ST_CHECK;
                    end
                    else
                    begin
                        step_next = ST_START;
                        pop       = 1'b1;
                    end
                end
                ST_DATA_STUFF:
                begin
                    if (head_cmd.last)
                    begin
                        step_next = ST_CHECK;
                    end
                    else
                    begin
                        step_next = ST_START;
                        pop       = 1'b1;
                    end
                end
                ST_CHECK:       step_next = check_hit ? ST_CHECK_STUFF : ST_CLOSE;
                ST_CHECK_STUFF: step_next = ST_CLOSE;
                ST_CLOSE:
                begin
                    step_next = ST_START;
                    pop       = 1'b1;
                end
                default:        step_next = ST_START;
            endcase
        end
    end

    always_comb
    begin
        emit_byte      = '0;
        emit_run_end   = 1'b0;
        emit_frame_end = 1'b0;
        case (cur_step)
            ST_HDR_FLAG:    emit_byte = cfg.flag;
            ST_HDR_ADDR:    emit_byte = cfg.address;
            ST_HDR_CTRL:    emit_byte = ctrl;
            ST_HDR_XOR:     emit_byte = cfg.address ^ ctrl;
            ST_DATA:
            begin
                emit_byte    = data_hit ? cfg.escape : head_cmd.data;
                emit_run_end = !data_hit && !head_cmd.last;
            end
            ST_DATA_STUFF:
            begin
                emit_byte    = head_cmd.data ^ STUFF_MASK;
                emit_run_end = !head_cmd.last;
            end
            ST_CHECK:       emit_byte = check_hit ? cfg.escape : head_cmd.check;
            ST_CHECK_STUFF: emit_byte = head_cmd.check ^ STUFF_MASK;
            ST_CLOSE:
            begin
                emit_byte      = cfg.flag;
                emit_run_end   = 1'b1;
                emit_frame_end = 1'b1;
            end
            default:        emit_byte = '0;
        endcase
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_byte_reg <= emit_byte;
            run_end_reg   <= emit_run_end;
            frame_end_reg <= emit_frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign line_byte = line_byte_reg;
    assign run_end   = run_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// File: src/byte_stuffed_frame_encoder.sv
// Top level of the byte-stuffed frame encoder with its configuration registers.
// The front end takes one payload request per cycle while its command queue (QUEUE_DEPTH
// entries) has room; the line sequencer behind it sends exactly one line byte per cycle
// when the output is not stalled and the queue is not empty. A payload byte becomes one
// line byte, or two when it is escaped; the first byte of a frame adds four header bytes and
// the last byte adds two or three trailer bytes (check byte, its escape if needed, closing
// flag). Sustained throughput is set by the line sequencer's one-byte-per-cycle output
// register. There is no clearing pass after reset; the configuration registers come up at
// their defaults and may be written whenever no frame bytes are in flight.
module byte_stuffed_frame_encoder
    import bfe_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    payload_byte,
    input  logic                 last_byte,
    input  logic                 sequence_bit,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    line_byte,
    output logic                 run_end,
    output logic                 frame_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head_cmd;
    logic queue_empty;
    logic queue_full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FLAG:      cfg_next.flag      = cfg_data;
                REG_ESCAPE:    cfg_next.escape    = cfg_data;
                REG_ADDRESS:   cfg_next.address   = cfg_data;
                REG_CTRL_SEQ0: cfg_next.ctrl_seq0 = cfg_data;
                REG_CTRL_SEQ1: cfg_next.ctrl_seq1 = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag      <= RESET_FLAG;
            cfg_reg.escape    <= RESET_ESCAPE;
            cfg_reg.address   <= RESET_ADDRESS;
            cfg_reg.ctrl_seq0 <= RESET_CTRL_SEQ0;
            cfg_reg.ctrl_seq1 <= RESET_CTRL_SEQ1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .sequence_bit (sequence_bit),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    bfe_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    bfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_cmd    (head_cmd),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_byte   (line_byte),
        .run_end     (run_end),
        .frame_end   (frame_end)
    );

endmodule

// File: dv/byte_stuffed_frame_encoder_test.sv
// Self-checking testbench for the byte-stuffed frame encoder: directed table, then random frames.
module byte_stuffed_frame_encoder_test;

    import bfe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS = 18;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 18;
    localparam int IDLE_PCT = 23;
    localparam int SETTLE_CYCLES = 8;
    localparam int CFG_BITS = $bits(cfg_t);
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [BYTE_W-1:0] line;
        logic              run_end;
        logic              frame_end;
    } line_out_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              seq;
        logic [3:0]        n_bytes;
        logic [71:0]       bytes;
    } stim_row_t;

    // Rows with a nonzero byte count carry the expected line bytes, first byte leftmost.
    stim_row_t dir_table [DIR_ROWS] = '{
        '{8'h41, 1'b1, 1'b0, 4'd7, 72'h7E03000341417E},
        '{8'h7E, 1'b1, 1'b1, 4'd9, 72'h7E0340437D5E7D5E7E},
        '{8'h7D, 1'b0, 1'b0, 4'd6, 72'h7E0300037D5D},
        '{8'h7D, 1'b1, 1'b1, 4'd4, 72'h7D5D007E},
        '{8'hFF, 1'b0, 1'b1, 4'd5, 72'h7E034043FF},
        '{8'h00, 1'b0, 1'b0, 4'd1, 72'h00},
        '{8'h81, 1'b1, 1'b0, 4'd4, 72'h817D5E7E},
        '{8'h5E, 1'b0, 1'b0, 4'd5, 72'h7E0300035E},
        '{8'h5D, 1'b0, 1'b1, 4'd1, 72'h5D},
        '{8'h20, 1'b0, 1'b1, 4'd0, 72'h0},
        '{8'hA5, 1'b0, 1'b0, 4'd0, 72'h0},
        '{8'h01, 1'b1, 1'b1, 4'd0, 72'h0},
        '{8'h80, 1'b1, 1'b1, 4'd7, 72'h7E03404380807E},
        '{8'h7E, 1'b0, 1'b0, 4'd0, 72'h0},
        '{8'h7D, 1'b0, 1'b1, 4'd0, 72'h0},
        '{8'h7E, 1'b1, 1'b0, 4'd0, 72'h0},
        '{8'h55, 1'b0, 1'b0, 4'd0, 72'h0},
        '{8'hAA, 1'b1, 1'b1, 4'd0, 72'h0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [BYTE_W-1:0] payload_byte = '0;
    logic last_byte = 1'b0;
    logic sequence_bit = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [BYTE_W-1:0] line_byte;
    logic run_end;
    logic frame_end;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0] cfg_data = '0;

    // Encoder state as predicted by the testbench.
    logic [BYTE_W-1:0] pred_flag = RESET_FLAG;
    logic [BYTE_W-1:0] pred_escape = RESET_ESCAPE;
    logic [BYTE_W-1:0] pred_address = RESET_ADDRESS;
    logic [BYTE_W-1:0] pred_ctrl0 = RESET_CTRL_SEQ0;
    logic [BYTE_W-1:0] pred_ctrl1 = RESET_CTRL_SEQ1;
    logic pred_open = 1'b0;
    logic [BYTE_W-1:0] pred_check = '0;

    line_out_t encoded_q[$];
    line_out_t pending_line_q[$];

    logic [3:0] req_typed_n = '0;
    logic [71:0] req_typed_bytes = '0;
    logic quiet = 1'b0;
    int mismatches = 0;
    int cycle_count = 0;

    byte_stuffed_frame_encoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .sequence_bit (sequence_bit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_byte    (line_byte),
        .run_end      (run_end),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got 'h%0h, expected 'h%0h", what, got, want);
        mismatches++;
    endtask

    function automatic void emit_line(input logic [BYTE_W-1:0] b, input logic fend);
        line_out_t item;
        item.line = b;
        item.run_end = 1'b0;
        item.frame_end = fend;
        encoded_q.push_back(item);
    endfunction

    function automatic void emit_stuffed(input logic [BYTE_W-1:0] b);
        if (b == pred_flag || b == pred_escape)
        begin
            emit_line(pred_escape, 1'b0);
            emit_line(b ^ STUFF_MASK, 1'b0);
        end
        else
        begin
            emit_line(b, 1'b0);
        end
    endfunction

    function automatic void frame_encode(input logic [BYTE_W-1:0] data, input logic last,
                                         input logic seq);
        logic [BYTE_W-1:0] ctrl;
        encoded_q.delete();
        if (!pred_open)
        begin
            ctrl = seq ? pred_ctrl1 : pred_ctrl0;
            emit_line(pred_flag, 1'b0);
            emit_line(pred_address, 1'b0);
            emit_line(ctrl, 1'b0);
            emit_line(pred_address ^ ctrl, 1'b0);
            pred_open = 1'b1;
            pred_check = '0;
        end
        emit_stuffed(data);
        pred_check = pred_check ^ data;
        if (last)
        begin
            emit_stuffed(pred_check);
            emit_line(pred_flag, 1'b1);
            pred_open = 1'b0;
            pred_check = '0;
        end
        encoded_q[encoded_q.size() - 1].run_end = 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [BYTE_W-1:0] value);
        case (idx)
            REG_FLAG: pred_flag = value;
            REG_ESCAPE: pred_escape = value;
            REG_ADDRESS: pred_address = value;
            REG_CTRL_SEQ0: pred_ctrl0 = value;
            REG_CTRL_SEQ1: pred_ctrl1 = value;
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin : monitor
        line_out_t want;
        line_out_t typed;
        int k;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_line_q.size() == 0)
                begin
                    report_mismatch("unexpected line byte", int'(line_byte), 0);
                end
                else
                begin
                    want = pending_line_q.pop_front();
                    if (line_byte !== want.line)
                        report_mismatch("line_byte", int'(line_byte), int'(want.line));
                    if (run_end !== want.run_end)
                        report_mismatch("run_end", int'(run_end), int'(want.run_end));
                    if (frame_end !== want.frame_end)
                        report_mismatch("frame_end", int'(frame_end), int'(want.frame_end));
                end
            end
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                frame_encode(payload_byte, last_byte, sequence_bit);
                if (req_typed_n != 0)
                begin
                    for (k = 0; k < req_typed_n; k++)
                    begin
                        typed.line = req_typed_bytes[(req_typed_n - 1 - k) * 8 +: 8];
                        typed.run_end = (k == req_typed_n - 1);
                        typed.frame_end = (k == req_typed_n - 1) && last_byte;
                        pending_line_q.push_back(typed);
                    end
                end
                else
                begin
                    foreach (encoded_q[k])
                        pending_line_q.push_back(encoded_q[k]);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic send_request(input logic [BYTE_W-1:0] data, input logic last,
                                input logic seq, input logic [3:0] n_typed,
                                input logic [71:0] typed_bytes);
        while (!quiet && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            payload_byte <= BYTE_W'($urandom_range(255));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        payload_byte <= data;
        last_byte <= last;
        sequence_bit <= seq;
        req_typed_n <= n_typed;
        req_typed_bytes <= typed_bytes;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_line_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_payload();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return pred_flag;
        else if (r < 40)
            return pred_escape;
        else if (r < 50)
            return pred_flag ^ STUFF_MASK;
        else if (r < 55)
            return pred_escape ^ STUFF_MASK;
        return BYTE_W'($urandom_range(255));
    endfunction

    initial
    begin : stimulus
        cfg_t phase_cfg [PHASES];
        int p;
        int i;
        int frame_left;
        phase_cfg[0] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        phase_cfg[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        phase_cfg[2] = '{8'h7E, 8'h7E, 8'h7E, 8'h5E, 8'h7E};
        phase_cfg[3] = '{8'h55, 8'h75, 8'h75, 8'h55, 8'h20};
        phase_cfg[4] = '{RESET_FLAG, RESET_ESCAPE, RESET_ADDRESS, RESET_CTRL_SEQ0,
                         RESET_CTRL_SEQ1};
        for (p = 5; p < PHASES; p++)
            phase_cfg[p] = CFG_BITS'({$urandom, $urandom});

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_table[i])
            send_request(dir_table[i].data, dir_table[i].last, dir_table[i].seq,
                         dir_table[i].n_bytes, dir_table[i].bytes);

        // Phases end on an item count, so many settings change while a frame is open.
        frame_left = 0;
        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_reg(REG_FLAG, phase_cfg[p].flag);
            write_reg(REG_ESCAPE, phase_cfg[p].escape);
            write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      BYTE_W'($urandom_range(255)));
            write_reg(REG_ADDRESS, phase_cfg[p].address);
            write_reg(REG_CTRL_SEQ0, phase_cfg[p].ctrl_seq0);
            write_reg(REG_CTRL_SEQ1, phase_cfg[p].ctrl_seq1);
            cfg_valid <= 1'b0;
            @(negedge clk);
            quiet <= (p == 5);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (frame_left == 0)
                    frame_left = ($urandom_range(9) == 0) ? $urandom_range(7, 14)
                                                          : $urandom_range(1, 4);
                send_request(pick_payload(), frame_left == 1, 1'($urandom_range(1)),
                             4'd0, 72'h0);
                frame_left--;
            end
        end
        quiet <= 1'b0;
        wait_drained();
        repeat (20) @(negedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
